// ===== src/fqm_pkg.sv =====
// ----------------------------------------------------------------------------
// fqm_pkg: shared types and constants for the min-tracking queue
// Command codes, decoded operation codes, result status codes and the
// word that travels from the front end to the execution back end.
// ----------------------------------------------------------------------------
package fqm_pkg;

    // command codes as they arrive on the input port
    localparam logic [2:0] CMD_ENQUEUE = 3'd0;
    localparam logic [2:0] CMD_DEQUEUE = 3'd1;
    localparam logic [2:0] CMD_FRONT   = 3'd2;
    localparam logic [2:0] CMD_SIZE    = 3'd3;
    localparam logic [2:0] CMD_CLEAR   = 3'd4;
    localparam logic [2:0] CMD_MIN     = 3'd5;

    // decoded operation codes carried through the command queue
    typedef logic [2:0] t_op_code;
    localparam t_op_code OP_ENQUEUE = 3'd0;
    localparam t_op_code OP_DEQUEUE = 3'd1;
    localparam t_op_code OP_FRONT   = 3'd2;
    localparam t_op_code OP_SIZE    = 3'd3;
    localparam t_op_code OP_CLEAR   = 3'd4;
    localparam t_op_code OP_MIN     = 3'd5;
    localparam t_op_code OP_BAD     = 3'd6;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ERR  = 2'd1;
    localparam logic [1:0] ST_DATA = 2'd2;

    localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        t_op_code           code;
        logic signed [31:0] value;
    } t_op;

    // back-end status seen by the top level
    typedef struct packed {
        logic               empty;
        logic               scanning;
        logic signed [31:0] minimum;
    } t_back_stat;

endpackage

// ===== src/fqm_front.sv =====
// ----------------------------------------------------------------------------
// fqm_front: command intake and classification
// Accepts input words, maps command codes to operations (unused codes to
// a bad-op marker) and pushes them into the command queue.
// ----------------------------------------------------------------------------
module fqm_front import fqm_pkg::*; (
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_command,
    input  logic signed [31:0] i_push_value,
    input  logic               i_full,
    output logic               o_push,
    output t_op                o_op
);

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_op.value = i_push_value;
        unique case (i_command)
            CMD_ENQUEUE: o_op.code = OP_ENQUEUE;
            CMD_DEQUEUE: o_op.code = OP_DEQUEUE;
            CMD_FRONT:   o_op.code = OP_FRONT;
            CMD_SIZE:    o_op.code = OP_SIZE;
            CMD_CLEAR:   o_op.code = OP_CLEAR;
            CMD_MIN:     o_op.code = OP_MIN;
            default:     o_op.code = OP_BAD;
        endcase
    end

endmodule

// ===== src/fqm_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// fqm_cmd_queue: two-entry queue between front end and back end
// Holds decoded operations so that intake and execution stall separately.
// ----------------------------------------------------------------------------
module fqm_cmd_queue import fqm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_op  o_op
);

    t_op        r_slot [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_cnt, n_cnt;
    logic       pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_op    = r_slot[r_rd_ptr];
    assign pop     = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push;
        n_rd_ptr = r_rd_ptr ^ pop;
        n_cnt    = r_cnt + {1'b0, i_push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // hold payload until overwritten
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_op;
        end
    end

endmodule

// ===== src/fqm_back.sv =====
// ----------------------------------------------------------------------------
// fqm_back: execution engine with entry memory and minimum rescan
// Runs one operation at a time against the circular store, keeps the
// running minimum and rescans the live entries when the minimum leaves.
// ----------------------------------------------------------------------------
module fqm_back import fqm_pkg::*; #(
    parameter int unsigned DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_op_valid,
    input  t_op                i_op,
    output logic               o_op_ready,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_result_value,
    output t_back_stat         o_stat
);

    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rd_data;

    logic [1:0]         r_state, n_state;
    logic [ADDR_W-1:0]  r_head, n_head;
    logic [ADDR_W-1:0]  r_tail, n_tail;
    logic [CNT_W-1:0]   r_count, n_count;
    logic signed [31:0] r_min, n_min;
    logic [ADDR_W-1:0]  r_scan_ptr, n_scan_ptr;
    logic [CNT_W-1:0]   r_scan_left, n_scan_left;
    logic               r_scan_dv, n_scan_dv;
    logic               r_is_deq, n_is_deq;
    logic               r_out_valid, n_out_valid;
    logic [1:0]         r_out_status, n_out_status;
    logic signed [31:0] r_out_value, n_out_value;

    logic               out_free;
    logic               wr_en;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;

    function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] p);
        logic [ADDR_W-1:0] q;
        if (p == ADDR_W'(DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + 1'b1;
        end
        return q;
    endfunction

    assign out_free   = !r_out_valid || i_ready;
    assign o_op_ready = (r_state == S_IDLE) && out_free;

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_min        = r_min;
        n_scan_ptr   = r_scan_ptr;
        n_scan_left  = r_scan_left;
        n_scan_dv    = 1'b0;
        n_is_deq     = r_is_deq;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (i_op_valid && out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_ERR;
                    n_out_value  = '0;
                    unique case (i_op.code)
                        OP_ENQUEUE: begin
                            if (r_count != CNT_W'(DEPTH)) begin
                                wr_en        = 1'b1;
                                n_tail       = next_slot(r_tail);
                                n_count      = r_count + 1'b1;
                                n_out_status = ST_OK;
                                if (i_op.value < r_min) begin
                                    n_min = i_op.value;
                                end
                            end
                        end
                        OP_DEQUEUE, OP_FRONT: begin
                            if (r_count != '0) begin
                                // fetch head; result goes out once data returns
                                rd_en       = 1'b1;
                                n_is_deq    = (i_op.code == OP_DEQUEUE);
                                n_out_valid = r_out_valid && !i_ready;
                                n_state     = S_READ;
                            end
                        end
                        OP_SIZE: begin
                            n_out_status = ST_DATA;
                            n_out_value  = 32'(r_count);
                        end
                        OP_CLEAR: begin
                            n_head       = '0;
                            n_tail       = '0;
                            n_count      = '0;
                            n_min        = INT_MAX;
                            n_out_status = ST_OK;
                        end
                        OP_MIN: begin
                            if (r_count != '0) begin
                                n_out_status = ST_DATA;
                                n_out_value  = r_min;
                            end
                        end
                        default: begin
                            n_out_status = ST_ERR;
                        end
                    endcase
                end
            end
            S_READ: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_DATA;
                    n_out_value  = r_rd_data;
                    n_state      = S_IDLE;
                    if (r_is_deq) begin
                        n_head  = next_slot(r_head);
                        n_count = r_count - 1'b1;
                        if (r_count == CNT_W'(1)) begin
                            n_min = INT_MAX;
                        end else if (r_rd_data == r_min) begin
                            n_min       = INT_MAX;
                            n_scan_ptr  = next_slot(r_head);
                            n_scan_left = r_count - 1'b1;
                            n_state     = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (r_scan_left != '0) begin
                    rd_en       = 1'b1;
                    rd_addr     = r_scan_ptr;
                    n_scan_ptr  = next_slot(r_scan_ptr);
                    n_scan_left = r_scan_left - 1'b1;
                    n_scan_dv   = 1'b1;
                end
                if (r_scan_dv && (r_rd_data < r_min)) begin
                    n_min = r_rd_data;
                end
                if ((r_scan_left == '0) && !r_scan_dv) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_min       <= INT_MAX;
            r_scan_ptr  <= '0;
            r_scan_left <= '0;
            r_scan_dv   <= 1'b0;
            r_is_deq    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_min       <= n_min;
            r_scan_ptr  <= n_scan_ptr;
            r_scan_left <= n_scan_left;
            r_scan_dv   <= n_scan_dv;
            r_is_deq    <= n_is_deq;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
    end

    // entry store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_tail] <= i_op.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_result_value = r_out_value;

    assign o_stat.empty    = (r_count == '0);
    assign o_stat.scanning = (r_state == S_SCAN);
    assign o_stat.minimum  = r_min;

endmodule

// ===== src/fifo_queue_with_minimum.sv =====
// Path: enqueue, size, clear and min go through the command queue into the
//   output register; dequeue and front also pass a registered memory read.
// Intake: one command per cycle into a 2-word command queue while it is not
//   full; the back end takes a command only when idle with its output free,
//   and a dequeue that removes the minimum then rescans the remaining entries.
// Reset: synchronous, active low; empties the queue, minimum to INT_MAX.
// ----------------------------------------------------------------------------
// fifo_queue_with_minimum: bounded FIFO of signed words tracking its minimum
// Front end decodes commands into a short queue; the back end executes them
// against a circular entry memory and produces one result word per command.
// ----------------------------------------------------------------------------
module fifo_queue_with_minimum import fqm_pkg::*; #(
    parameter int unsigned DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_command,
    input  logic signed [31:0] i_push_value,
    // result channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_result_value
);

    // front end -> command queue
    logic       push;
    t_op        front_op;
    logic       queue_full;

    // command queue -> back end
    logic       queue_valid;
    t_op        queue_op;
    logic       back_ready;

    t_back_stat back_stat;

    // Decode each accepted word and push it; stall intake only when the
    // command queue is full, which a waiting result causes once two more
    // words have queued up behind it.
    fqm_front u_front (
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_command    (i_command),
        .i_push_value (i_push_value),
        .i_full       (queue_full),
        .o_push       (push),
        .o_op         (front_op)
    );

    // Decouple intake from execution.
    fqm_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .i_pop   (back_ready),
        .o_op    (queue_op)
    );

    // Execute one operation at a time; the result sits in an output
    // register, and the back end advances as soon as that register frees.
    fqm_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op_valid     (queue_valid),
        .i_op           (queue_op),
        .o_op_ready     (back_ready),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_result_value (o_result_value),
        .o_stat         (back_stat)
    );

    // An empty queue always reports the reset minimum.
    a_empty_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_stat.empty |-> (back_stat.minimum == INT_MAX))
        else $error("empty queue holds a stale minimum");

    // A rescan only runs while entries remain.
    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_stat.scanning |-> !back_stat.empty)
        else $error("minimum rescan on an empty queue");

    // Results without data carry a zero value.
    a_nodata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ((o_status == ST_OK) || (o_status == ST_ERR)))
            |-> (o_result_value == '0))
        else $error("nonzero value on a result without data");

endmodule

// ===== verif/fifo_queue_with_minimum_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fifo_queue_with_minimum_tb: self-checking bench for the min-tracking queue
// A typed table walks the empty-queue errors, the value extremes and the
// minimum rescans. Random episodes follow: mixed traffic, monotone runs and
// noise. One episode fills the queue past full and then drains it through
// a pointer wrap. Results are checked against a shadow queue or pinned rows.
// ----------------------------------------------------------------------------
module fifo_queue_with_minimum_tb import fqm_pkg::*; ();

    localparam int unsigned DEPTH = 1024;
    // words counted toward the random part (unused codes excluded)
    localparam int RANDOM_ITEMS = 580;
    // timeout: generous budget of words, each allowed a full rescan plus
    // the longest gap on both sides, taken four times over
    localparam int ITEM_BUDGET = 3200;
    localparam int CYCLE_LIMIT = 4 * ITEM_BUDGET * (DEPTH + 16);
    localparam int DRAIN_CYCLES = 32;
    localparam int REPORT_MAX = 10;

    // command codes the package leaves unnamed; the block answers them with
    // an error and changes nothing
    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;

    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] value;
    } t_answer;

    typedef struct {
        logic [2:0]         cmd;
        logic signed [31:0] val;
        bit                 pinned;
        logic [1:0]         st;
        logic signed [31:0] res;
    } t_stim_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [2:0]         i_command;
    logic signed [31:0] i_push_value;
    logic               o_valid;
    logic               i_ready;
    logic [1:0]         o_status;
    logic signed [31:0] o_result_value;

    // shadow copy of the queue state
    logic signed [31:0] shadow_mem [DEPTH];
    int unsigned        shadow_head;
    int unsigned        shadow_tail;
    int unsigned        shadow_count;
    logic signed [31:0] shadow_min;

    t_answer   pending_answers [$];
    t_stim_row stim_table [$];

    int bad_count;
    int live_items;
    int send_calm;
    int recv_calm;
    int cycle_count;

    fifo_queue_with_minimum #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_command     (i_command),
        .i_push_value  (i_push_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_result_value(o_result_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Shadow queue: apply one command and return the answer it must give.
    function automatic void queue_predict(input logic [2:0] cmd,
                                          input logic signed [31:0] val,
                                          output t_answer ans);
        int unsigned        p;
        logic signed [31:0] out_word;
        ans.status = ST_ERR;
        out_word   = '0;
        case (cmd)
            CMD_ENQUEUE: begin
                if (shadow_count < DEPTH) begin
                    shadow_mem[shadow_tail] = val;
                    shadow_tail = (shadow_tail + 1) % DEPTH;
                    shadow_count++;
                    if (val < shadow_min) shadow_min = val;
                    ans.status = ST_OK;
                end
            end
            CMD_DEQUEUE: begin
                if (shadow_count != 0) begin
                    out_word = shadow_mem[shadow_head];
                    shadow_head = (shadow_head + 1) % DEPTH;
                    shadow_count--;
                    ans.status = ST_DATA;
                    if (shadow_count == 0) begin
                        shadow_min = INT_MAX;
                    end else if (out_word == shadow_min) begin
                        // removed the minimum: rescan what is left
                        shadow_min = INT_MAX;
                        p = shadow_head;
                        repeat (shadow_count) begin
                            if (shadow_mem[p] < shadow_min) shadow_min = shadow_mem[p];
                            p = (p + 1) % DEPTH;
                        end
                    end
                end
            end
            CMD_FRONT: begin
                if (shadow_count != 0) begin
                    out_word   = shadow_mem[shadow_head];
                    ans.status = ST_DATA;
                end
            end
            CMD_SIZE: begin
                out_word   = 32'(shadow_count);
                ans.status = ST_DATA;
            end
            CMD_CLEAR: begin
                shadow_head  = 0;
                shadow_tail  = 0;
                shadow_count = 0;
                shadow_min   = INT_MAX;
                ans.status   = ST_OK;
            end
            CMD_MIN: begin
                if (shadow_count != 0) begin
                    out_word   = shadow_min;
                    ans.status = ST_DATA;
                end
            end
            default: ;
        endcase
        ans.value = out_word;
    endfunction

    // Idle length for one word; now and then start a stretch with no idling.
    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 6);
    endfunction

    // Mix of extremes, a narrow band that repeats the minimum, and full range.
    function automatic logic signed [31:0] pick_value();
        int r;
        int s;
        r = $urandom_range(0, 15);
        case (r)
            0: return INT_MAX;
            1: return INT_MIN;
            2: return 32'sd0;
            3: return -32'sd1;
            4, 5, 6, 7, 8: begin
                s = $urandom_range(0, 16);
                return s - 8;
            end
            default: return $urandom;
        endcase
    endfunction

    // Lean toward dequeue once the queue grows, so it stays shallow.
    function automatic logic [2:0] pick_cmd();
        int r;
        int enq_w;
        enq_w = (shadow_count > 40) ? 20 : 45;
        r = $urandom_range(0, 99);
        if (r < enq_w) return CMD_ENQUEUE;
        if (r < 75) return CMD_DEQUEUE;
        if (r < 82) return CMD_FRONT;
        if (r < 88) return CMD_SIZE;
        if (r < 95) return CMD_MIN;
        if (r < 97) return CMD_CLEAR;
        return $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
    endfunction

    function automatic void add_row(input logic [2:0] cmd, input logic signed [31:0] val,
                                    input bit pinned, input logic [1:0] st,
                                    input logic signed [31:0] res);
        t_stim_row row;
        row.cmd    = cmd;
        row.val    = val;
        row.pinned = pinned;
        row.st     = st;
        row.res    = res;
        stim_table.push_back(row);
    endfunction

    // Present one command word, hold it until accepted, then log its answer.
    // A pinned word carries its answer in the table instead of the shadow's.
    task automatic issue_cmd(input logic [2:0] cmd, input logic signed [31:0] val,
                             input bit pinned = 1'b0, input logic [1:0] pin_st = ST_OK,
                             input logic signed [31:0] pin_val = 32'sd0);
        t_answer guess;
        int      gap;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_command    <= cmd;
        i_push_value <= val;
        @(posedge i_clk);
        while (o_ready !== 1'b1) @(posedge i_clk);
        queue_predict(cmd, val, guess);
        if (pinned) begin
            guess.status = pin_st;
            guess.value  = pin_val;
        end
        pending_answers.push_back(guess);
        if (cmd <= CMD_MIN) live_items++;
    endtask

    // Timeout guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: stall at random, then check each accepted word against
    // the oldest expectation.
    initial begin : result_sink
        t_answer want;
        int      gap;
        i_ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            gap = draw_gap(recv_calm);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (o_valid !== 1'b1) @(posedge i_clk);
            if (pending_answers.size() == 0) begin
                bad_count++;
                if (bad_count <= REPORT_MAX)
                    $display("unexpected result word: status %0d value %0d",
                             o_status, o_result_value);
            end else begin
                want = pending_answers.pop_front();
                if (o_status !== want.status || o_result_value !== want.value) begin
                    bad_count++;
                    if (bad_count <= REPORT_MAX)
                        $display({"result mismatch: expected status %0d value %0d, ",
                                  "got status %0d value %0d"},
                                 want.status, $signed(want.value), o_status,
                                 o_result_value);
                end
            end
        end
    end

    initial begin : stimulus
        int          kind;
        int          n;
        int          v;
        int          step;
        int          r;
        bit          up;
        logic [2:0]  cmd;
        t_stim_row   row;

        bad_count    = 0;
        live_items   = 0;
        send_calm    = 0;
        recv_calm    = 0;
        cycle_count  = 0;
        shadow_head  = 0;
        shadow_tail  = 0;
        shadow_count = 0;
        shadow_min   = INT_MAX;

        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_command    <= CMD_SIZE;
        i_push_value <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table. Rows left unpinned follow a rescan and go to the
        // shadow queue for their answer.
        add_row(CMD_FRONT,   32'sd0,  1, ST_ERR,  32'sd0);   // empty queue errors
        add_row(CMD_DEQUEUE, 32'sd0,  1, ST_ERR,  32'sd0);
        add_row(CMD_MIN,     32'sd0,  1, ST_ERR,  32'sd0);
        add_row(CMD_SIZE,    -32'sd1, 1, ST_DATA, 32'sd0);
        add_row(CMD_SPARE_A, INT_MIN, 1, ST_ERR,  32'sd0);   // unused codes
        add_row(CMD_SPARE_B, -32'sd1, 1, ST_ERR,  32'sd0);
        add_row(CMD_ENQUEUE, INT_MAX, 1, ST_OK,   32'sd0);
        add_row(CMD_MIN,     32'sd0,  1, ST_DATA, INT_MAX);
        add_row(CMD_ENQUEUE, INT_MIN, 1, ST_OK,   32'sd0);
        add_row(CMD_MIN,     32'sd0,  1, ST_DATA, INT_MIN);
        add_row(CMD_ENQUEUE, 32'sd0,  1, ST_OK,   32'sd0);
        add_row(CMD_ENQUEUE, -32'sd1, 1, ST_OK,   32'sd0);
        add_row(CMD_SIZE,    32'sd0,  1, ST_DATA, 32'sd4);
        add_row(CMD_FRONT,   32'sd0,  1, ST_DATA, INT_MAX);
        add_row(CMD_DEQUEUE, 32'sd0,  1, ST_DATA, INT_MAX);  // not the minimum
        add_row(CMD_DEQUEUE, 32'sd0,  1, ST_DATA, INT_MIN);  // minimum leaves
        add_row(CMD_MIN,     32'sd0,  0, ST_OK,   32'sd0);
        add_row(CMD_ENQUEUE, -32'sd1, 1, ST_OK,   32'sd0);   // duplicate minimum
        add_row(CMD_DEQUEUE, 32'sd0,  1, ST_DATA, 32'sd0);
        add_row(CMD_DEQUEUE, 32'sd0,  1, ST_DATA, -32'sd1);  // one copy remains
        add_row(CMD_MIN,     32'sd0,  0, ST_OK,   32'sd0);
        add_row(CMD_DEQUEUE, 32'sd0,  1, ST_DATA, -32'sd1);  // now empty
        add_row(CMD_ENQUEUE, 32'sd5,  1, ST_OK,   32'sd0);
        add_row(CMD_CLEAR,   INT_MAX, 1, ST_OK,   32'sd0);
        add_row(CMD_MIN,     32'sd0,  1, ST_ERR,  32'sd0);
        foreach (stim_table[i]) begin
            row = stim_table[i];
            issue_cmd(row.cmd, row.val, row.pinned, row.st, row.res);
        end

        // Random episodes until enough live words have gone in.
        live_items = 0;
        while (live_items < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 19);
            if (kind < 12) begin
                // mixed traffic
                n = $urandom_range(4, 20);
                repeat (n) issue_cmd(pick_cmd(), pick_value());
            end else if (kind < 17) begin
                // monotone run: rising on a cleared queue puts the minimum at the head
                // of each dequeue, so each one but the last forces a rescan
                if ($urandom_range(0, 1)) issue_cmd(CMD_CLEAR, pick_value());
                n    = $urandom_range(2, 12);
                v    = $urandom_range(0, 20000);
                v    = v - 10000;
                step = $urandom_range(0, 50);
                up   = $urandom_range(0, 3) != 0;
                repeat (n) begin
                    issue_cmd(CMD_ENQUEUE, v);
                    v = up ? v + step : v - step;
                end
                repeat (n) begin
                    if ($urandom_range(0, 3) == 0) issue_cmd(CMD_MIN, pick_value());
                    issue_cmd(CMD_DEQUEUE, pick_value());
                end
            end else begin
                // noise: queries, removals and stray codes on whatever is held
                n = $urandom_range(2, 6);
                repeat (n) begin
                    r = $urandom_range(0, 5);
                    case (r)
                        0: cmd = CMD_DEQUEUE;
                        1: cmd = CMD_FRONT;
                        2: cmd = CMD_MIN;
                        3: cmd = CMD_CLEAR;
                        4: cmd = CMD_SIZE;
                        default: cmd = $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
                    endcase
                    issue_cmd(cmd, pick_value());
                end
            end
        end

        // Fill past full, refill across the tail wrap, then drain to empty so
        // the head wraps too.
        issue_cmd(CMD_CLEAR, pick_value());
        while (shadow_count < DEPTH) issue_cmd(CMD_ENQUEUE, pick_value());
        repeat (3) issue_cmd(CMD_ENQUEUE, pick_value());
        issue_cmd(CMD_SIZE, pick_value());
        issue_cmd(CMD_MIN, pick_value());
        issue_cmd(CMD_FRONT, pick_value());
        repeat (24) begin
            issue_cmd(CMD_DEQUEUE, pick_value());
            if ($urandom_range(0, 3) == 0) issue_cmd(CMD_MIN, pick_value());
        end
        repeat (25) issue_cmd(CMD_ENQUEUE, pick_value());
        issue_cmd(CMD_SIZE, pick_value());
        while (shadow_count != 0) begin
            issue_cmd(CMD_DEQUEUE, pick_value());
            r = $urandom_range(0, 7);
            if (r == 0) issue_cmd(CMD_MIN, pick_value());
            else if (r == 1) issue_cmd(CMD_FRONT, pick_value());
        end
        issue_cmd(CMD_DEQUEUE, pick_value());
        issue_cmd(CMD_MIN, pick_value());
        repeat (4) issue_cmd(CMD_ENQUEUE, pick_value());
        issue_cmd(CMD_MIN, pick_value());
        issue_cmd(CMD_CLEAR, pick_value());
        issue_cmd(CMD_SIZE, pick_value());

        // Drop valid, wait out every answer, then watch for strays.
        i_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (bad_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/fqm_pkg.sv
src/fqm_front.sv
src/fqm_cmd_queue.sv
src/fqm_back.sv
src/fifo_queue_with_minimum.sv
verif/fifo_queue_with_minimum_tb.sv
